@@ hw/rtl/dual_bank_record_selector_defines.svh @@
// ----------------------------------------------------------------------------
// dual_bank_record_selector_defines.svh
// Assertion macros shared by the record selector modules. Each macro samples
// on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_BANK_RECORD_SELECTOR_DEFINES_SVH
`define DUAL_BANK_RECORD_SELECTOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define DRBS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("drbs assertion failed");

// Consequent that holds in the cycle after the antecedent
`define DRBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drbs assertion failed");

`endif

@@ hw/rtl/drbs_pkg.sv @@
// ----------------------------------------------------------------------------
// drbs_pkg
// Types, constants and the CRC-32 byte update for the dual bank record
// selector.
// ----------------------------------------------------------------------------
package drbs_pkg;

    // Defaults for top level parameters
    localparam int PAGE_BYTES_DEF  = 2048;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Record layout
    localparam int          LEN_W       = 11;
    localparam logic [10:0] LEN_RESET   = 11'd2028;
    localparam int          HDR_BYTES   = 16;
    localparam int          CRC_BYTES   = 4;
    localparam logic [31:0] REC_MAGIC   = 32'h5048_4F4E;
    localparam logic [31:0] REC_VERSION = 32'd1;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    // Header word slots
    localparam logic [1:0] HDR_MAGIC   = 2'd0;
    localparam logic [1:0] HDR_VERSION = 2'd1;
    localparam logic [1:0] HDR_SEQ     = 2'd2;
    localparam logic [1:0] HDR_LENGTH  = 2'd3;

    // Page codes
    localparam logic PAGE_A = 1'b0;
    localparam logic PAGE_B = 1'b1;

    // Chosen page codes
    localparam logic [1:0] CHOSEN_NONE = 2'd0;
    localparam logic [1:0] CHOSEN_A    = 2'd1;
    localparam logic [1:0] CHOSEN_B    = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       page_select;
        logic       page_end;
    } in_item_t;

    typedef struct packed {
        logic        page_echo;
        logic        page_ok;
        logic [31:0] page_sequence;
        logic [1:0]  chosen_page;
        logic [31:0] chosen_sequence;
        logic        next_write_page;
    } out_item_t;

    // Judged page, front to back
    typedef struct packed {
        logic        page;
        logic        ok;
        logic [31:0] seq_num;
    } page_rec_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/drbs_front.sv @@
// ----------------------------------------------------------------------------
// drbs_front
// Parses the byte stream of one page image: collects the header words, runs
// the CRC over the payload, collects the stored CRC and judges the page on
// its end byte. Also holds the payload length register.
// ----------------------------------------------------------------------------
`include "dual_bank_record_selector_defines.svh"

module drbs_front
    import drbs_pkg::*;
#(
    parameter int PAGE_BYTES = PAGE_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output page_rec_t        q_data
);

    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam int CW = (PW > LEN_W + 1) ? PW : LEN_W + 1;

    logic [LEN_W-1:0] len_reg;
    logic [PW-1:0]    pos_reg,  pos_next;
    logic [31:0]      crc_reg,  crc_next;
    logic [31:0]      chk_reg,  chk_next;
    logic [31:0]      hdr_reg  [4];
    logic [31:0]      hdr_next [4];

    logic          accept;
    logic          in_range;
    logic [CW-1:0] pos_ext;
    logic [CW-1:0] pay_end;
    logic [CW-1:0] rec_end;
    logic [1:0]    chk_lane;
    logic          page_ok;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Region boundaries of the record
    assign pos_ext  = CW'(pos_reg);
    assign pay_end  = CW'(HDR_BYTES) + CW'(len_reg);
    assign rec_end  = pay_end + CW'(CRC_BYTES);
    assign in_range = pos_reg < PW'(PAGE_BYTES);
    assign chk_lane = pos_reg[1:0] - len_reg[1:0];

    // Byte parse
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        chk_next = chk_reg;
        for (int i = 0; i < 4; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        if (accept && in_range)
        begin
            if (pos_ext < CW'(HDR_BYTES))
            begin
                hdr_next[pos_reg[3:2]] = hdr_reg[pos_reg[3:2]]
                    | (32'(item.data_byte) << {pos_reg[1:0], 3'b000});
            end
            else if (pos_ext < pay_end)
            begin
                crc_next = crc_byte(crc_reg, item.data_byte);
            end
            else if (pos_ext < rec_end)
            begin
                chk_next = chk_reg | (32'(item.data_byte) << {chk_lane, 3'b000});
            end
            pos_next = pos_reg + PW'(1);
        end
    end

    // Page verdict on the end byte
    assign page_ok = (CW'(pos_next) >= rec_end)
                  && (hdr_next[HDR_MAGIC] == REC_MAGIC)
                  && (hdr_next[HDR_VERSION] == REC_VERSION)
                  && (hdr_next[HDR_LENGTH] == 32'(len_reg))
                  && ((crc_next ^ CRC_INIT) == chk_next);

    assign q_push         = accept && item.page_end;
    assign q_data.page    = item.page_select;
    assign q_data.ok      = page_ok;
    assign q_data.seq_num = hdr_next[HDR_SEQ];

    // Parse state, cleared after each page end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
            chk_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else if (q_push)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
            chk_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            chk_reg <= chk_next;
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    // Payload length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_data;
        end
    end

    // Position saturates at the page size
    `DRBS_ASSERT_ALWAYS(a_pos_bound, pos_reg <= PW'(PAGE_BYTES))

endmodule

@@ hw/rtl/drbs_queue.sv @@
// ----------------------------------------------------------------------------
// drbs_queue
// Short queue of judged pages between the parser and the selector.
// ----------------------------------------------------------------------------
`include "dual_bank_record_selector_defines.svh"

module drbs_queue
    import drbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  page_rec_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output page_rec_t rd_data,
    output logic      empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    page_rec_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg,  count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = count_reg == NW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Occupancy stays within depth
    `DRBS_ASSERT_ALWAYS(a_q_count, count_reg <= NW'(DEPTH))
    // A write into a full queue would drop a page
    `DRBS_ASSERT_ALWAYS(a_q_no_drop, !(wr_en && full))

endmodule

@@ hw/rtl/drbs_back.sv @@
// ----------------------------------------------------------------------------
// drbs_back
// Records each judged page in the bank table, picks the newest valid page
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "dual_bank_record_selector_defines.svh"

module drbs_back
    import drbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  page_rec_t q_data,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic        valid_reg [2];
    logic [31:0] seq_reg   [2];
    logic        valid_next [2];
    logic [31:0] seq_next   [2];
    logic        out_valid_reg, out_valid_next;
    out_item_t   result_reg,    result_next;
    logic        take;
    logic        b_newer;
    logic [1:0]  chosen;

    assign take   = !q_empty && (!out_valid_reg || pop);
    assign q_pop  = take;
    assign empty  = !out_valid_reg;
    assign result = result_reg;

    // Bank table with the incoming page applied
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            valid_next[i] = valid_reg[i];
            seq_next[i]   = seq_reg[i];
        end
        if (take)
        begin
            valid_next[q_data.page] = q_data.ok;
            seq_next[q_data.page]   = q_data.seq_num;
        end
    end

    // Newest valid page, A wins ties
    assign b_newer = seq_next[PAGE_B] > seq_next[PAGE_A];

    always_comb
    begin
        if (valid_next[PAGE_A] && valid_next[PAGE_B])
        begin
            chosen = b_newer ? CHOSEN_B : CHOSEN_A;
        end
        else if (valid_next[PAGE_A])
        begin
            chosen = CHOSEN_A;
        end
        else if (valid_next[PAGE_B])
        begin
            chosen = CHOSEN_B;
        end
        else
        begin
            chosen = CHOSEN_NONE;
        end
    end

    // Result assembly
    always_comb
    begin
        result_next.page_echo       = q_data.page;
        result_next.page_ok         = q_data.ok;
        result_next.page_sequence   = q_data.seq_num;
        result_next.chosen_page     = chosen;
        result_next.next_write_page = (chosen == CHOSEN_A) ? PAGE_B : PAGE_A;
        case (chosen)
            CHOSEN_A: result_next.chosen_sequence = seq_next[PAGE_A];
            CHOSEN_B: result_next.chosen_sequence = seq_next[PAGE_B];
            default:  result_next.chosen_sequence = '0;
        endcase
    end

    assign out_valid_next = take ? 1'b1 : (pop ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                valid_reg[i] <= 1'b0;
                seq_reg[i]   <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 2; i++)
            begin
                valid_reg[i] <= valid_next[i];
                seq_reg[i]   <= seq_next[i];
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    // A held result stays until taken
    `DRBS_ASSERT_NEXT(a_hold, out_valid_reg && !pop, out_valid_reg)
    // No valid page means a zero chosen sequence
    `DRBS_ASSERT_ALWAYS(a_none_zero,
        !out_valid_reg || (result_reg.chosen_page != CHOSEN_NONE)
        || (result_reg.chosen_sequence == '0))

endmodule

@@ hw/rtl/dual_bank_record_selector.sv @@
// ----------------------------------------------------------------------------
// dual_bank_record_selector
// Validates dual bank flash page images and picks the newest valid page.
// ----------------------------------------------------------------------------
// One page image byte is taken per clock cycle while full is low, with no
// gaps between bytes or pages. The parser runs the header capture and the
// byte-wide CRC-32 update in the cycle a byte is taken, and on the end byte
// passes the verdict into a small queue. The selector takes one verdict per
// cycle when no result waits unpopped, updates the bank table and registers
// the result. full rises only when the queue is full, which happens only
// while results are left unpopped. payload_length must be written while idle.
module dual_bank_record_selector
    import drbs_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    output logic             empty,
    input  logic             pop,
    output out_item_t        result,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    page_rec_t q_wr_data;
    page_rec_t q_rd_data;

    // Byte parser and page judge
    drbs_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    // Verdict queue
    drbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Bank selection and result register
    drbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
